/* hw/rtl/bsf_pkg.sv */
// shared types and constants of the bad sector filter
`default_nettype none

package bsf_pkg;

	localparam int TABLE_DEPTH  = 64;
	localparam int SECTOR_BYTES = 512;
	localparam int MAX_LENGTH   = 131072;

	localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
	localparam int OFFSET_W     = 40;
	localparam int DISK_W       = 41;
	localparam int LEN_W        = 18;
	localparam int SECTOR_W     = 31;
	localparam int SPARE_W      = 16;
	localparam int COUNT_W      = 7;
	localparam int CFG_INDEX_W  = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_DISK_BYTES  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_TOTAL = 2'd1;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_READ  = 2'd2,
		OP_WRITE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_IO_ERROR   = 2'd1,
		ST_PAST_END   = 2'd2,
		ST_TABLE_FULL = 2'd3
	} status_t;

	typedef struct packed {
		op_t                 op;
		logic [OFFSET_W-1:0] byte_offset;
		logic [LEN_W-1:0]    length;
		logic [SECTOR_W-1:0] sector_number;
	} req_item_t;

	typedef struct packed {
		status_t            status;
		logic [LEN_W-1:0]   granted_length;
		logic [SPARE_W-1:0] spares_left;
		logic [COUNT_W-1:0] bad_count;
	} rsp_item_t;

	typedef struct packed {
		logic [CFG_INDEX_W-1:0] index;
		logic [DISK_W-1:0]      value;
	} cfg_item_t;

	// contents of one table cell, moved between neighbors
	typedef struct packed {
		logic                valid;
		logic                ge;
		logic                le;
		logic [SECTOR_W-1:0] value;
	} cell_t;

	typedef struct packed {
		logic clear;
		logic insert;
		logic scan;
		logic remove;
	} cell_cmd_t;

	typedef struct packed {
		logic [SECTOR_W-1:0] sec;
		logic [SECTOR_W-1:0] lo;
		logic [SECTOR_W-1:0] hi;
	} cell_key_t;

	typedef struct packed {
		logic any_hit;
		logic dup;
	} chain_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/bsf_if.sv */
// valid/ready channel interfaces of the bad sector filter
`default_nettype none

interface bsf_req_if;
	logic               valid;
	logic               ready;
	bsf_pkg::req_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bsf_rsp_if;
	logic               valid;
	logic               ready;
	bsf_pkg::rsp_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bsf_cfg_if;
	logic               valid;
	logic               ready;
	bsf_pkg::cfg_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bsf_cell.sv */
// one cell of the sorted bad sector chain
`default_nettype none

module bsf_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  bsf_pkg::cell_cmd_t  cmd,
	input  bsf_pkg::cell_key_t  key,
	input  bsf_pkg::cell_t      left,
	input  wire                 left_gt,
	input  bsf_pkg::cell_t      right,
	output bsf_pkg::cell_t      cur,
	output logic                gt,
	output logic                eq,
	output logic                hit
);

	logic                         valid_q;
	logic                         ge_q;
	logic                         le_q;
	logic [bsf_pkg::SECTOR_W-1:0] value_q;
	logic                         shift;

	// invalid cells sort above every sector
	assign gt    = !valid_q || (value_q > key.sec);
	assign eq    = valid_q && (value_q == key.sec);
	assign hit   = valid_q && ge_q && le_q;
	assign shift = !valid_q || ge_q;

	assign cur.valid = valid_q;
	assign cur.ge    = ge_q;
	assign cur.le    = le_q;
	assign cur.value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
		end else if (cmd.insert && gt) begin
			valid_q <= left_gt ? left.valid : 1'b1;
		end else if (cmd.remove && shift) begin
			valid_q <= right.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert && gt) begin
			value_q <= left_gt ? left.value : key.sec;
			ge_q    <= left.ge;
			le_q    <= left.le;
		end else if (cmd.scan) begin
			ge_q <= value_q >= key.lo;
			le_q <= value_q <= key.hi;
		end else if (cmd.remove && shift) begin
			value_q <= right.value;
			ge_q    <= right.ge;
			le_q    <= right.le;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/bsf_ctrl.sv */
// sequencer, clipping arithmetic, counters and result register
`default_nettype none

module bsf_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	bsf_req_if.sink                req,
	bsf_rsp_if.source              rsp,
	bsf_cfg_if.sink                cfg,
	input  bsf_pkg::chain_stat_t   stat,
	output bsf_pkg::cell_cmd_t     cmd,
	output bsf_pkg::cell_key_t     key
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_EXEC   = 6'b000010,
		S_RANGE  = 6'b000100,
		S_SCAN   = 6'b001000,
		S_REPAIR = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	state_t                         state_q;
	state_t                         state_d;
	bsf_pkg::op_t                   op_q;
	logic [bsf_pkg::OFFSET_W-1:0]   off_q;
	logic [bsf_pkg::LEN_W-1:0]      len_q;
	logic [bsf_pkg::SECTOR_W-1:0]   sec_q;
	logic [bsf_pkg::SECTOR_W-1:0]   lo_q;
	logic [bsf_pkg::SECTOR_W-1:0]   hi_q;
	logic [bsf_pkg::DISK_W-1:0]     disk_q;
	logic [bsf_pkg::SPARE_W-1:0]    spare_total_q;
	logic [bsf_pkg::SPARE_W-1:0]    spare_q;
	logic [bsf_pkg::COUNT_W-1:0]    count_q;
	bsf_pkg::status_t               status_q;
	logic [bsf_pkg::LEN_W-1:0]      gran_q;
	logic                           out_valid_q;

	logic                           req_fire;
	logic                           cfg_fire;
	logic                           out_load;
	logic                           full;
	logic                           past;
	logic [bsf_pkg::LEN_W-1:0]      len_sat;
	logic [bsf_pkg::DISK_W-1:0]     room;
	logic [bsf_pkg::LEN_W-1:0]      grant;
	logic [bsf_pkg::DISK_W-1:0]     end_addr;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign req_fire  = req.valid && req.ready;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign out_load  = (state_q == S_FINISH) && (!out_valid_q || rsp.ready);
	assign full      = (count_q == bsf_pkg::COUNT_W'(bsf_pkg::TABLE_DEPTH));

	assign past     = bsf_pkg::DISK_W'(off_q) >= disk_q;
	assign len_sat  = (len_q > bsf_pkg::LEN_W'(bsf_pkg::MAX_LENGTH)) ?
		bsf_pkg::LEN_W'(bsf_pkg::MAX_LENGTH) : len_q;
	assign room     = disk_q - bsf_pkg::DISK_W'(off_q);
	assign grant    = (bsf_pkg::DISK_W'(len_sat) > room) ?
		room[bsf_pkg::LEN_W-1:0] : len_sat;
	// inclusive last byte of the access
	assign end_addr = bsf_pkg::DISK_W'(off_q) + bsf_pkg::DISK_W'(gran_q)
		- bsf_pkg::DISK_W'(1);

	assign key.sec = sec_q;
	assign key.lo  = lo_q;
	assign key.hi  = hi_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_FINISH;
				unique case (op_q)
					bsf_pkg::OP_CLEAR: cmd.clear = 1'b1;
					bsf_pkg::OP_ADD:   cmd.insert = !stat.dup && !full;
					bsf_pkg::OP_READ, bsf_pkg::OP_WRITE: begin
						if (!past) state_d = S_RANGE;
					end
				endcase
			end
			S_RANGE: begin
				state_d = (gran_q == '0) ? S_FINISH : S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				state_d  = S_REPAIR;
			end
			S_REPAIR: begin
				if (op_q == bsf_pkg::OP_WRITE && stat.any_hit && spare_q != '0) begin
					cmd.remove = 1'b1;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			disk_q        <= '0;
			spare_total_q <= '0;
			spare_q       <= '0;
			count_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_fire) begin
				unique case (cfg.data.index)
					bsf_pkg::CFG_DISK_BYTES:  disk_q <= cfg.data.value;
					bsf_pkg::CFG_SPARE_TOTAL: spare_total_q <= cfg.data.value[bsf_pkg::SPARE_W-1:0];
					default: ;
				endcase
			end
			if (cmd.clear) begin
				count_q <= '0;
				spare_q <= spare_total_q;
			end else if (cmd.insert) begin
				count_q <= count_q + bsf_pkg::COUNT_W'(1);
			end else if (cmd.remove) begin
				count_q <= count_q - bsf_pkg::COUNT_W'(1);
				spare_q <= spare_q - bsf_pkg::SPARE_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q  <= req.data.op;
			off_q <= req.data.byte_offset;
			len_q <= req.data.length;
			sec_q <= req.data.sector_number;
		end
		if (state_q == S_EXEC) begin
			if (op_q == bsf_pkg::OP_ADD && !stat.dup && full) begin
				status_q <= bsf_pkg::ST_TABLE_FULL;
			end else if ((op_q == bsf_pkg::OP_READ || op_q == bsf_pkg::OP_WRITE) && past) begin
				status_q <= bsf_pkg::ST_PAST_END;
			end else begin
				status_q <= bsf_pkg::ST_OK;
			end
			if ((op_q == bsf_pkg::OP_READ || op_q == bsf_pkg::OP_WRITE) && !past) begin
				gran_q <= grant;
			end else begin
				gran_q <= '0;
			end
		end
		if (state_q == S_RANGE) begin
			lo_q <= bsf_pkg::SECTOR_W'(off_q >> bsf_pkg::SECTOR_SHIFT);
			hi_q <= bsf_pkg::SECTOR_W'(end_addr >> bsf_pkg::SECTOR_SHIFT);
		end
		if (state_q == S_REPAIR && stat.any_hit) begin
			if (op_q == bsf_pkg::OP_READ || spare_q == '0) begin
				status_q <= bsf_pkg::ST_IO_ERROR;
			end
		end
		if (out_load) begin
			rsp.data.status         <= status_q;
			rsp.data.granted_length <= (status_q == bsf_pkg::ST_OK) ? gran_q : '0;
			rsp.data.spares_left    <= spare_q;
			rsp.data.bad_count      <= count_q;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/bad_sector_filter_with_spares.sv */
// top level: bad sector table as a sorted chain of cells with spare repair
//
// req carries one operation per transaction: clear, add bad sector, read
// access or write access. rsp returns exactly one result per operation, in
// order. cfg writes disk_bytes (index 0) and spare_total (index 1); the user
// must write them only while the block is idle; the block does not enforce
// this; cfg.ready is always high. The table is a row of cells kept sorted by
// sector number. An add shifts the cells above the new sector one place up;
// a repair removes the lowest covered sector by shifting the cells above it
// one place down. Clear, add and an access that starts past the disk end pass
// S_EXEC and S_FINISH; a zero length access adds S_RANGE, a read S_RANGE,
// S_SCAN and S_REPAIR, and a write repeats S_REPAIR per repaired sector.
// One operation is in work at a time; req.ready returns high in the cycle
// after the result is loaded into the output register, so the next operation
// is taken while that result still waits on rsp.ready. A stalled rsp holds
// its data and the block stops before loading the next result.
// Reset empties the table and clears the spare count and both registers.
`default_nettype none

module bad_sector_filter_with_spares (
	input  wire        clk,
	input  wire        arst_n,
	bsf_req_if.sink    req,
	bsf_rsp_if.source  rsp,
	bsf_cfg_if.sink    cfg
);

	bsf_pkg::cell_cmd_t                 cmd;
	bsf_pkg::cell_key_t                 key;
	bsf_pkg::chain_stat_t               stat;
	bsf_pkg::cell_t                     cells [bsf_pkg::TABLE_DEPTH];
	logic [bsf_pkg::TABLE_DEPTH-1:0]    gt_vec;
	logic [bsf_pkg::TABLE_DEPTH-1:0]    eq_vec;
	logic [bsf_pkg::TABLE_DEPTH-1:0]    hit_vec;

	assign stat.any_hit = |hit_vec;
	assign stat.dup     = |eq_vec;

	bsf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.stat   (stat),
		.cmd    (cmd),
		.key    (key)
	);

	for (genvar i = 0; i < bsf_pkg::TABLE_DEPTH; i++) begin : g_cell
		bsf_pkg::cell_t left;
		bsf_pkg::cell_t right;
		logic           left_gt;

		if (i == 0) begin : g_first
			assign left    = '0;
			assign left_gt = 1'b0;
		end else begin : g_mid
			assign left    = cells[i-1];
			assign left_gt = gt_vec[i-1];
		end

		if (i == bsf_pkg::TABLE_DEPTH - 1) begin : g_last
			assign right = '0;
		end else begin : g_inner
			assign right = cells[i+1];
		end

		bsf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.key     (key),
			.left    (left),
			.left_gt (left_gt),
			.right   (right),
			.cur     (cells[i]),
			.gt      (gt_vec[i]),
			.eq      (eq_vec[i]),
			.hit     (hit_vec[i])
		);
	end

endmodule

`default_nettype wire

/* hw/rtl/bsf_checker.sv */
// port checker for the bad sector filter and its bind
`default_nettype none

module bsf_checker (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 rsp_valid,
	input  wire                 rsp_ready,
	input  bsf_pkg::rsp_item_t  rsp_data
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_data))
		else $error("rsp data changed while stalled");

	a_err_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != bsf_pkg::ST_OK |->
			rsp_data.granted_length == '0)
		else $error("length granted on a failed transaction");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == bsf_pkg::ST_TABLE_FULL |->
			rsp_data.bad_count == bsf_pkg::COUNT_W'(bsf_pkg::TABLE_DEPTH))
		else $error("table full reported below capacity");

	a_grant_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.granted_length <= bsf_pkg::LEN_W'(bsf_pkg::MAX_LENGTH))
		else $error("granted length above maximum");

endmodule

bind bad_sector_filter_with_spares bsf_checker u_bsf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire

/* tb/sv/bad_sector_filter_with_spares_tb.sv */
`timescale 1ns / 1ps
// testbench of the bad sector filter: directed table, then random phases against a predictor

module bad_sector_filter_with_spares_tb;
	import bsf_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 20;
	localparam int PHASE_ITEMS = 195;

	localparam logic [CFG_INDEX_W-1:0] CFG_NONE_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_NONE_HI = 2'd3;

	localparam logic [DISK_W-1:0]   DISK_MAX = 41'h100_0000_0000;
	localparam logic [OFFSET_W-1:0] OFF_END  = 40'hFF_FFFF_FFFF;
	localparam logic [OFFSET_W-1:0] OFF_LAST = 40'hFF_FFFF_FE00;
	localparam logic [OFFSET_W-1:0] OFF_PREV = 40'hFF_FFFF_FC00;
	localparam logic [SECTOR_W-1:0] SEC_LAST = 31'h7FFF_FFFF;
	localparam logic [LEN_W-1:0]    LEN_ALL  = 18'h3FFFF;

	typedef struct packed {
		logic                is_cfg;
		logic [DISK_W-1:0]   disk;
		logic [SPARE_W-1:0]  spares;
		op_t                 op;
		logic [OFFSET_W-1:0] off;
		logic [LEN_W-1:0]    len;
		logic [SECTOR_W-1:0] sec;
		logic                typed;
		rsp_item_t           want;
	} dir_row_t;

	localparam rsp_item_t NO_RSP = '0;

	localparam dir_row_t DIRECTED [26] = '{
		'{1'b0, 41'd0, 16'd0, OP_READ, 40'd0, 18'd512, 31'd0, 1'b1,
			'{ST_PAST_END, 18'd0, 16'd0, 7'd0}},
		'{1'b0, 41'd0, 16'd0, OP_WRITE, OFF_END, LEN_ALL, SEC_LAST, 1'b1,
			'{ST_PAST_END, 18'd0, 16'd0, 7'd0}},
		'{1'b1, DISK_MAX, 16'd2, OP_CLEAR, 40'd0, 18'd0, 31'd0, 1'b0, NO_RSP},
		'{1'b0, 41'd0, 16'd0, OP_CLEAR, 40'd0, 18'd0, 31'd0, 1'b1,
			'{ST_OK, 18'd0, 16'd2, 7'd0}},
		'{1'b0, 41'd0, 16'd0, OP_ADD, 40'd0, 18'd0, 31'd0, 1'b1,
			'{ST_OK, 18'd0, 16'd2, 7'd1}},
		'{1'b0, 41'd0, 16'd0, OP_ADD, 40'd0, 18'd0, 31'd0, 1'b1,
			'{ST_OK, 18'd0, 16'd2, 7'd1}},
		'{1'b0, 41'd0, 16'd0, OP_ADD, 40'd0, 18'd0, SEC_LAST, 1'b1,
			'{ST_OK, 18'd0, 16'd2, 7'd2}},
		'{1'b0, 41'd0, 16'd0, OP_ADD, 40'd0, 18'd0, 31'd5, 1'b1,
			'{ST_OK, 18'd0, 16'd2, 7'd3}},
		'{1'b0, 41'd0, 16'd0, OP_ADD, 40'd0, 18'd0, 31'd7, 1'b1,
			'{ST_OK, 18'd0, 16'd2, 7'd4}},
		'{1'b0, 41'd0, 16'd0, OP_READ, 40'd0, 18'd0, 31'd0, 1'b1,
			'{ST_OK, 18'd0, 16'd2, 7'd4}},
		'{1'b0, 41'd0, 16'd0, OP_READ, 40'd2048, 18'd512, 31'd0, 1'b1,
			'{ST_OK, 18'd512, 16'd2, 7'd4}},
		'{1'b0, 41'd0, 16'd0, OP_READ, 40'd2048, 18'd513, 31'd0, 1'b1,
			'{ST_IO_ERROR, 18'd0, 16'd2, 7'd4}},
		'{1'b0, 41'd0, 16'd0, OP_READ, 40'd1024, LEN_ALL, 31'd0, 1'b0, NO_RSP},
		'{1'b0, 41'd0, 16'd0, OP_READ, OFF_LAST, LEN_ALL, 31'd0, 1'b1,
			'{ST_IO_ERROR, 18'd0, 16'd2, 7'd4}},
		'{1'b0, 41'd0, 16'd0, OP_READ, OFF_PREV, 18'd512, 31'd0, 1'b1,
			'{ST_OK, 18'd512, 16'd2, 7'd4}},
		'{1'b0, 41'd0, 16'd0, OP_READ, OFF_END, 18'd0, 31'd0, 1'b1,
			'{ST_OK, 18'd0, 16'd2, 7'd4}},
		'{1'b0, 41'd0, 16'd0, OP_READ, OFF_END, 18'd131072, 31'd0, 1'b0, NO_RSP},
		'{1'b0, 41'd0, 16'd0, OP_WRITE, 40'd0, 18'd4096, 31'd0, 1'b0, NO_RSP},
		'{1'b0, 41'd0, 16'd0, OP_WRITE, OFF_LAST, 18'd131072, 31'd0, 1'b1,
			'{ST_IO_ERROR, 18'd0, 16'd0, 7'd2}},
		'{1'b0, 41'd0, 16'd0, OP_READ, 40'd512, 18'd512, 31'd0, 1'b0, NO_RSP},
		'{1'b1, 41'd5000, 16'hFFFF, OP_CLEAR, 40'd0, 18'd0, 31'd0, 1'b0, NO_RSP},
		'{1'b0, 41'd0, 16'd0, OP_CLEAR, 40'd0, 18'd0, 31'd0, 1'b1,
			'{ST_OK, 18'd0, 16'hFFFF, 7'd0}},
		'{1'b0, 41'd0, 16'd0, OP_ADD, 40'd0, 18'd0, 31'd9, 1'b0, NO_RSP},
		'{1'b0, 41'd0, 16'd0, OP_WRITE, 40'd4000, 18'd4096, 31'd0, 1'b0, NO_RSP},
		'{1'b0, 41'd0, 16'd0, OP_WRITE, 40'd5000, 18'd1, 31'd0, 1'b1,
			'{ST_PAST_END, 18'd0, 16'hFFFE, 7'd0}},
		'{1'b0, 41'd0, 16'd0, OP_READ, 40'd4999, 18'd131072, 31'd0, 1'b0, NO_RSP}
	};

	logic clk;
	logic arst_n;

	bsf_req_if req_if ();
	bsf_rsp_if rsp_if ();
	bsf_cfg_if cfg_if ();

	bad_sector_filter_with_spares u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	// shadow of the filter state
	logic [SECTOR_W-1:0] held_sec [TABLE_DEPTH];
	logic                bad_used [TABLE_DEPTH];
	int                  bad_total;
	logic [SPARE_W-1:0]  spares_avail;
	logic [DISK_W-1:0]   disk_limit;
	logic [SPARE_W-1:0]  spare_reload;

	rsp_item_t pending [$];
	int        mismatches;
	int        send_idle_pct;
	int        recv_idle_pct;
	int        stall_cycles;
	logic [63:0] win_base;
	int          win_len;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic [OFFSET_W-1:0] any40();
		return {8'($urandom_range(0, 255)), 32'($urandom)};
	endfunction

	function automatic int lowest_bad(logic [63:0] lo, logic [63:0] hi);
		int best;
		best = -1;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (bad_used[i] && 64'(held_sec[i]) >= lo && 64'(held_sec[i]) <= hi) begin
				if (best < 0 || held_sec[i] < held_sec[best])
					best = i;
			end
		end
		return best;
	endfunction

	function automatic status_t insert_bad(logic [SECTOR_W-1:0] s);
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (bad_used[i] && held_sec[i] == s)
				return ST_OK;
		if (bad_total >= TABLE_DEPTH)
			return ST_TABLE_FULL;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (!bad_used[i]) begin
				held_sec[i] = s;
				bad_used[i] = 1'b1;
				bad_total++;
				return ST_OK;
			end
		end
		return ST_TABLE_FULL;
	endfunction

	function automatic rsp_item_t compute_outcome(req_item_t it);
		rsp_item_t   r;
		logic [63:0] off, room, g, first, last;
		int          k;
		r = '0;
		r.status = ST_OK;
		off = 64'(it.byte_offset);
		case (it.op)
			OP_CLEAR: begin
				foreach (bad_used[i])
					bad_used[i] = 1'b0;
				bad_total = 0;
				spares_avail = spare_reload;
			end
			OP_ADD: r.status = insert_bad(it.sector_number);
			default: begin
				if (off >= 64'(disk_limit)) begin
					r.status = ST_PAST_END;
				end else begin
					room = 64'(disk_limit) - off;
					g = (it.length > MAX_LENGTH) ? 64'(MAX_LENGTH) : 64'(it.length);
					if (g > room)
						g = room;
					r.granted_length = g[LEN_W-1:0];
					if (g != 0) begin
						first = off >> SECTOR_SHIFT;
						last = (off + g - 1) >> SECTOR_SHIFT;
						if (it.op == OP_READ) begin
							if (lowest_bad(first, last) >= 0)
								r.status = ST_IO_ERROR;
						end else begin
							k = lowest_bad(first, last);
							while (k >= 0) begin
								if (spares_avail == 0) begin
									r.status = ST_IO_ERROR;
									break;
								end
								bad_used[k] = 1'b0;
								bad_total--;
								spares_avail--;
								k = lowest_bad(first, last);
							end
						end
					end
					if (r.status != ST_OK)
						r.granted_length = '0;
				end
			end
		endcase
		r.spares_left = spares_avail;
		r.bad_count = bad_total[COUNT_W-1:0];
		return r;
	endfunction

	function automatic req_item_t random_item();
		req_item_t it;
		int        pick;
		it.byte_offset = any40();
		it.length = 18'($urandom);
		it.sector_number = 31'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 3)
			it.op = OP_CLEAR;
		else if (pick < 35)
			it.op = OP_ADD;
		else if (pick < 67)
			it.op = OP_READ;
		else
			it.op = OP_WRITE;
		if ($urandom_range(0, 99) < 85) begin
			it.sector_number = 31'(win_base + 64'($urandom_range(0, win_len - 1)));
			it.byte_offset = 40'(((win_base + 64'($urandom_range(0, win_len - 1)))
				<< SECTOR_SHIFT) + 64'($urandom_range(0, 511)));
		end
		pick = $urandom_range(0, 99);
		if (pick < 10)
			it.length = '0;
		else if (pick < 20)
			it.length = 18'($urandom);
		else if (pick < 25)
			it.length = 18'(MAX_LENGTH);
		else
			it.length = 18'($urandom_range(1, 8192));
		return it;
	endfunction

	task automatic issue_op(input req_item_t it, input logic typed, input rsp_item_t given);
		rsp_item_t calc;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= it;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		calc = compute_outcome(it);
		pending.push_back(typed ? given : calc);
	endtask

	task automatic wait_drained();
		req_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending.size() != 0);
	endtask

	task automatic load_regs(input logic [DISK_W-1:0] disk, input logic [SPARE_W-1:0] spare);
		cfg_item_t writes [3];
		writes[0] = '{CFG_DISK_BYTES, disk};
		writes[1] = '{CFG_SPARE_TOTAL, 41'(spare)};
		writes[2] = '{($urandom_range(0, 1) != 0) ? CFG_NONE_HI : CFG_NONE_LO,
			{1'($urandom), any40()}};
		for (int i = 0; i < 3; i++) begin
			cfg_if.valid <= 1'b1;
			cfg_if.data <= writes[i];
			@(posedge clk);
			while (!cfg_if.ready)
				@(posedge clk);
			if (writes[i].index == CFG_DISK_BYTES)
				disk_limit = writes[i].value;
			else if (writes[i].index == CFG_SPARE_TOTAL)
				spare_reload = writes[i].value[SPARE_W-1:0];
		end
		cfg_if.valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
				|| (cfg_if.valid && cfg_if.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin : rsp_side
		rsp_item_t got, want;
		rsp_if.ready <= 1'b0;
		wait (arst_n);
		forever begin
			rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			@(posedge clk);
			if (rsp_if.valid && rsp_if.ready) begin
				got = rsp_if.data;
				if (pending.size() == 0) begin
					$error("result transaction with no operation outstanding");
					mismatches++;
				end else begin
					want = pending.pop_front();
					if (got.status != want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						mismatches++;
					end
					if (got.granted_length != want.granted_length) begin
						$error("granted_length: expected %0d, got %0d",
							want.granted_length, got.granted_length);
						mismatches++;
					end
					if (got.spares_left != want.spares_left) begin
						$error("spares_left: expected %0d, got %0d",
							want.spares_left, got.spares_left);
						mismatches++;
					end
					if (got.bad_count != want.bad_count) begin
						$error("bad_count: expected %0d, got %0d",
							want.bad_count, got.bad_count);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin : req_side
		req_item_t         it;
		logic [DISK_W-1:0] disk;
		logic [SPARE_W-1:0] spare;
		logic [63:0]       sectors;
		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.data <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.data <= '0;
		stall_cycles = 0;
		mismatches = 0;
		foreach (bad_used[i]) begin
			bad_used[i] = 1'b0;
			held_sec[i] = '0;
		end
		bad_total = 0;
		spares_avail = '0;
		disk_limit = '0;
		spare_reload = '0;
		win_base = '0;
		win_len = 32;
		send_idle_pct = 34;
		recv_idle_pct = 66;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].is_cfg) begin
				wait_drained();
				load_regs(DIRECTED[i].disk, DIRECTED[i].spares);
			end else begin
				it.op = DIRECTED[i].op;
				it.byte_offset = DIRECTED[i].off;
				it.length = DIRECTED[i].len;
				it.sector_number = DIRECTED[i].sec;
				issue_op(it, DIRECTED[i].typed, DIRECTED[i].want);
			end
		end

		for (int mode = 0; mode < 3; mode++) begin
			for (int p = 0; p < 3; p++) begin
				case (mode)
					0: begin
						send_idle_pct = 34;
						recv_idle_pct = 66;
					end
					1: begin
						send_idle_pct = 66;
						recv_idle_pct = 34;
					end
					default: begin
						send_idle_pct = 0;
						recv_idle_pct = 0;
					end
				endcase
				case ((mode * 3 + p) % 4)
					0: disk = DISK_MAX;
					1: disk = {1'b0, any40()};
					2: disk = 41'($urandom_range(512, 200000));
					default: disk = 41'($urandom_range(1 << 20, 1 << 30));
				endcase
				case ((mode + p) % 3)
					0: spare = '0;
					1: spare = '1;
					default: spare = 16'($urandom_range(1, 24));
				endcase
				wait_drained();
				load_regs(disk, spare);

				// hot window of sectors, often straddling the disk end
				sectors = 64'(disk) >> SECTOR_SHIFT;
				win_len = $urandom_range(32, 256);
				if (sectors <= 64'(win_len))
					win_base = '0;
				else if ($urandom_range(0, 1) != 0)
					win_base = sectors - 64'($urandom_range(1, win_len));
				else
					win_base = 64'($urandom_range(0, 32'(sectors - 64'(win_len))));

				it = random_item();
				it.op = OP_CLEAR;
				issue_op(it, 1'b0, NO_RSP);
				repeat (PHASE_ITEMS - 1)
					issue_op(random_item(), 1'b0, NO_RSP);
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
